// ----- hdl/sbbm_pkg.sv -----
`timescale 1ns / 1ps
// sbbm_pkg: shared types and constants of the sprite band bucket multiplexer
// item and result structs, mode and status codes, band-to-scanline helper
// no dependencies
package sbbm_pkg;

	// mode codes of an input item
	localparam logic [2:0] MODE_COUNT       = 3'd0;
	localparam logic [2:0] MODE_SPRITE      = 3'd1;
	localparam logic [2:0] MODE_SORT_DONE   = 3'd2;
	localparam logic [2:0] MODE_FRAME_START = 3'd3;
	localparam logic [2:0] MODE_LINE        = 3'd4;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_BAND  = 2'd1,
		STATUS_FULL      = 2'd2,
		STATUS_NO_BAND   = 2'd3
	} status_t;

	// line event scanline: (8k + offset) mod period
	localparam logic [8:0] LINE_OFFSET = 9'd218;
	localparam logic [8:0] LINE_PERIOD = 9'd228;
	localparam logic [7:0] TOTAL_MAX   = 8'd255;

	typedef struct packed {
		logic [2:0]        mode;
		logic [7:0]        band_count;
		logic [8:0]        sprite_x;
		logic signed [8:0] sprite_y;
	} item_t;

	typedef struct packed {
		logic [6:0]  slot;
		logic [15:0] attr_zero;
		logic [15:0] attr_one;
		logic [15:0] attr_two;
		logic [6:0]  first_source;
		logic [6:0]  first_dest;
		logic [7:0]  first_length;
		logic [6:0]  second_source;
		logic [7:0]  second_length;
		logic [7:0]  next_line;
		status_t     status;
	} result_t;

	// scanline of the line event for band k; k is at most 31
	function automatic logic [7:0] line_of_band(input logic [5:0] k);
		logic [8:0] v;
		v = {k, 3'b000} + LINE_OFFSET;
		if (v >= {LINE_PERIOD[7:0], 1'b0}) begin
			v = v - {LINE_PERIOD[7:0], 1'b0};
		end else if (v >= LINE_PERIOD) begin
			v = v - LINE_PERIOD;
		end
		return v[7:0];
	endfunction

endpackage

// ----- hdl/sbbm_engine.sv -----
`timescale 1ns / 1ps
// sbbm_engine: band tables, counters and the single-pass result logic
// depends on sbbm_pkg
module sbbm_engine #(
	parameter int BANDS       = 21,
	parameter int RING_SLOTS  = 128,
	parameter int STORE_SLOTS = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  sbbm_pkg::item_t  item,
	output sbbm_pkg::result_t res
);
	import sbbm_pkg::*;

	localparam int IW = $clog2(BANDS);
	localparam int BW = $clog2(BANDS + 1);
	localparam int RW = $clog2(RING_SLOTS);
	localparam logic [BW-1:0] BANDS_C = BW'(BANDS);
	localparam logic [5:0]    BANDS_6 = 6'(BANDS);
	localparam logic [8:0]    STORE_C = 9'(STORE_SLOTS);
	localparam logic [8:0]    RING_C  = 9'(RING_SLOTS);

	logic [7:0]    size_q  [BANDS];
	logic [7:0]    start_q [BANDS];
	logic [7:0]    fill_q  [BANDS];
	logic [7:0]    total_q;
	logic [BW-1:0] load_q;
	logic [BW-1:0] xfer_q;
	logic [1:0]    frame_q;
	logic [RW-1:0] ring_q;

	logic [9:0]    t;
	logic          neg, bad_band;
	logic [5:0]    bq, sel_band;
	logic          rd_ok;
	logic [IW-1:0] rd_idx, ld_idx;
	logic [7:0]    sz, st, fl;
	logic [8:0]    pos;
	logic          full, sprite_ok;
	logic          load_ok, xfer_ok;
	logic [8:0]    total_sum;
	logic [7:0]    total_sat;
	logic [8:0]    room, n, ring_sum, first, second;
	logic          wrap;
	logic [RW-1:0] ring_next;
	logic [BW-1:0] xfer_next;

	// band lookup for a sprite: (y + 8) / 8 truncated toward zero
	always_comb begin
		t        = {item.sprite_y[8], item.sprite_y} + 10'd8;
		neg      = t[9];
		bq       = t[8:3];
		bad_band = ($signed(t) < -10'sd7) || (!neg && (bq >= BANDS_6));
		sel_band = (item.mode == MODE_SPRITE) ? (neg ? 6'd0 : bq) : 6'(xfer_q);
		rd_ok    = sel_band < BANDS_6;
		rd_idx   = rd_ok ? sel_band[IW-1:0] : '0;
		ld_idx   = load_q[IW-1:0];
		load_ok  = load_q < BANDS_C;
		xfer_ok  = xfer_q < BANDS_C;
	end

	assign sz = size_q[rd_idx];
	assign st = start_q[rd_idx];
	assign fl = fill_q[rd_idx];

	always_comb begin
		pos       = {1'b0, st} + {1'b0, fl};
		full      = (fl >= sz) || (pos >= STORE_C);
		sprite_ok = !bad_band && !full;
		total_sum = {1'b0, total_q} + {1'b0, item.band_count};
		total_sat = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : total_sum[7:0];
	end

	// copy split at the ring wrap
	always_comb begin
		room = ({1'b0, st} < STORE_C) ? (STORE_C - {1'b0, st}) : 9'd0;
		n    = {1'b0, sz};
		if (n > RING_C) begin
			n = RING_C;
		end
		if (n > room) begin
			n = room;
		end
		ring_sum = 9'(ring_q) + n;
		wrap     = ring_sum > RING_C;
		first    = wrap ? (RING_C - 9'(ring_q)) : n;
		second   = wrap ? (n - first) : 9'd0;
		ring_next = (ring_sum >= RING_C) ? RW'(ring_sum - RING_C) : RW'(ring_sum);
	end

	always_comb begin
		xfer_next = xfer_q;
		if (item.mode == MODE_FRAME_START) begin
			xfer_next = '0;
		end else if (item.mode == MODE_LINE && xfer_ok) begin
			xfer_next = xfer_q + BW'(1);
		end
	end

	always_comb begin
		res           = '0;
		res.status    = STATUS_OK;
		res.next_line = (xfer_next < BANDS_C) ? line_of_band(6'(xfer_next)) : 8'd0;
		unique case (item.mode)
			MODE_COUNT: begin
				if (!load_ok) begin
					res.status = STATUS_NO_BAND;
				end
			end
			MODE_SPRITE: begin
				res.attr_zero = {8'd0, item.sprite_y[7:0]};
				res.attr_one  = {7'd0, item.sprite_x};
				res.attr_two  = 16'(frame_q) + 16'd1;
				if (bad_band) begin
					res.status = STATUS_BAD_BAND;
				end else if (full) begin
					res.status = STATUS_FULL;
				end else begin
					res.slot = pos[6:0];
				end
			end
			MODE_LINE: begin
				if (!xfer_ok) begin
					res.status = STATUS_NO_BAND;
				end else begin
					if (first != 9'd0) begin
						res.first_source = st[6:0];
						res.first_dest   = 7'(ring_q);
						res.first_length = first[7:0];
					end
					if (second != 9'd0) begin
						res.second_source = 7'(st + first[7:0]);
						res.second_length = second[7:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANDS; i++) begin
				size_q[i]  <= '0;
				start_q[i] <= '0;
				fill_q[i]  <= '0;
			end
			total_q <= '0;
			load_q  <= '0;
			xfer_q  <= '0;
			frame_q <= '0;
			ring_q  <= '0;
		end else if (fire) begin
			xfer_q <= xfer_next;
			unique case (item.mode)
				MODE_COUNT: begin
					if (load_ok) begin
						size_q[ld_idx]  <= item.band_count;
						start_q[ld_idx] <= total_q;
						fill_q[ld_idx]  <= '0;
						total_q         <= total_sat;
						load_q          <= load_q + BW'(1);
					end
				end
				MODE_SPRITE: begin
					if (sprite_ok) begin
						fill_q[rd_idx] <= fl + 8'd1;
					end
				end
				MODE_SORT_DONE: begin
					frame_q <= frame_q + 2'd1;
					load_q  <= '0;
					total_q <= '0;
				end
				MODE_FRAME_START: begin
					ring_q <= '0;
				end
				MODE_LINE: begin
					if (xfer_ok) begin
						ring_q <= ring_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- hdl/sprite_band_bucket_multiplexer.sv -----
`timescale 1ns / 1ps
// sprite_band_bucket_multiplexer: top level, input register, result register, handshake
// depends on sbbm_pkg and sbbm_engine
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall  | mode, band_count, sprite_x, sprite_y
//  out     | output    | out_valid / out_stall| slot, attr_*, first_*, second_*, next_line,
//          |           |                      | status
//
// one item per clock cycle sustained while out_stall stays low; a result goes through the
// input register, then the engine's single pass into the result register, before it is on
// the outputs
// the band tables hold a size, a start and a fill byte per band, read at one index per item
// arst_n clears all band tables, counters and both valid flags at once
// while a result waits, the input register can still take one item; in_stall rises only
// when both the input register and the result register are full
module sprite_band_bucket_multiplexer #(
	parameter int BANDS       = 21,
	parameter int RING_SLOTS  = 128,
	parameter int STORE_SLOTS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [7:0]  band_count,
	input  logic [8:0]  sprite_x,
	input  logic signed [8:0] sprite_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  slot,
	output logic [15:0] attr_zero,
	output logic [15:0] attr_one,
	output logic [15:0] attr_two,
	output logic [6:0]  first_source,
	output logic [6:0]  first_dest,
	output logic [7:0]  first_length,
	output logic [6:0]  second_source,
	output logic [7:0]  second_length,
	output logic [7:0]  next_line,
	output logic [1:0]  status
);
	import sbbm_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    in_xfer;

	// the item in the input register moves on when the result register is free or its result is taken
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload holds no reset
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.mode       <= mode;
			item_s1.band_count <= band_count;
			item_s1.sprite_x   <= sprite_x;
			item_s1.sprite_y   <= sprite_y;
		end
	end

	// state update and result logic; state changes on the same edge the result is taken
	sbbm_engine #(
		.BANDS       (BANDS),
		.RING_SLOTS  (RING_SLOTS),
		.STORE_SLOTS (STORE_SLOTS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid     = valid_s2;
	assign slot          = res_s2.slot;
	assign attr_zero     = res_s2.attr_zero;
	assign attr_one      = res_s2.attr_one;
	assign attr_two      = res_s2.attr_two;
	assign first_source  = res_s2.first_source;
	assign first_dest    = res_s2.first_dest;
	assign first_length  = res_s2.first_length;
	assign second_source = res_s2.second_source;
	assign second_length = res_s2.second_length;
	assign next_line     = res_s2.next_line;
	assign status        = res_s2.status;

	// a dropped or failed item never reports a store slot
	a_no_slot_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STATUS_OK) |-> slot == 7'd0)
		else $error("slot given with an error status");

	// the two copy segments together never exceed the ring
	a_copy_fits_ring: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, first_length} + {1'b0, second_length}) <= 9'(RING_SLOTS))
		else $error("copy segments exceed ring size");

	// an empty first segment carries no source or destination
	a_empty_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (first_length == 8'd0) |-> (first_source == 7'd0) && (first_dest == 7'd0))
		else $error("empty first segment with nonzero slots");

	// a wrapped segment only follows a first segment that runs to the ring end
	a_wrap_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (second_length != 8'd0) |->
			(9'(first_dest) + {1'b0, first_length}) == 9'(RING_SLOTS))
		else $error("wrapped segment without a first segment reaching the ring end");

	// stall is raised only with full input and result registers
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with room available");

endmodule

// ----- tb/sbbm_result_checker.sv -----
`timescale 1ns / 1ps
// sbbm_result_checker: watches both channels of the sprite band bucket multiplexer,
// predicts each result from its own band tables and compares them in arrival order
// depends on sbbm_pkg for the item and result types and the mode and status codes
module sbbm_result_checker #(
	parameter int BANDS       = 21,
	parameter int RING_SLOTS  = 128,
	parameter int STORE_SLOTS = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [2:0]        mode,
	input  logic [7:0]        band_count,
	input  logic [8:0]        sprite_x,
	input  logic signed [8:0] sprite_y,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [6:0]        slot,
	input  logic [15:0]       attr_zero,
	input  logic [15:0]       attr_one,
	input  logic [15:0]       attr_two,
	input  logic [6:0]        first_source,
	input  logic [6:0]        first_dest,
	input  logic [7:0]        first_length,
	input  logic [6:0]        second_source,
	input  logic [7:0]        second_length,
	input  logic [7:0]        next_line,
	input  logic [1:0]        status,
	output int                fail_count,
	output int                pending,
	output int                checked_count,
	output int                dropped_count,
	output int                split_count
);
	import sbbm_pkg::*;

	localparam int MAX_REPORTS = 10;
	localparam int IDX_W       = $clog2(BANDS + 1);

	// predicted band tables; starts keep eight bits since a saturated start lies past the store
	logic [7:0]       size_tab  [BANDS];
	logic [7:0]       start_tab [BANDS];
	logic [7:0]       fill_tab  [BANDS];
	logic [7:0]       total_q;
	logic [IDX_W-1:0] load_idx;
	logic [IDX_W-1:0] copy_idx;
	logic [1:0]       frame_q;
	logic [6:0]       ring_q;

	result_t expected_q [$];
	item_t   seen_item;
	result_t want;
	result_t got;

	function automatic result_t predict_band_result(input item_t it);
		result_t r;
		int      sum;
		int      t;
		int      band;
		int      pos;
		int      start;
		int      n;
		int      room;
		int      head_len;
		int      tail_len;
		r = '0;
		r.status = STATUS_OK;
		case (it.mode)
			MODE_COUNT: begin
				if (load_idx >= BANDS) begin
					r.status = STATUS_NO_BAND;
				end else begin
					size_tab[load_idx]  = it.band_count;
					start_tab[load_idx] = total_q;
					fill_tab[load_idx]  = '0;
					sum = int'(total_q) + int'(it.band_count);
					total_q = (sum > int'(TOTAL_MAX)) ? TOTAL_MAX : sum[7:0];
					load_idx = load_idx + 1'b1;
				end
			end
			MODE_SPRITE: begin
				t = $signed(it.sprite_y) + 8;
				r.attr_zero = {8'h00, it.sprite_y[7:0]};
				r.attr_one  = {7'h00, it.sprite_x};
				r.attr_two  = {14'h0000, frame_q} + 16'd1;
				if (t < -7 || t / 8 >= BANDS) begin
					r.status = STATUS_BAD_BAND;
				end else begin
					// -7..-1 truncates toward zero into band 0
					band = (t < 0) ? 0 : t / 8;
					pos = int'(start_tab[band]) + int'(fill_tab[band]);
					if (fill_tab[band] >= size_tab[band] || pos >= STORE_SLOTS) begin
						r.status = STATUS_FULL;
					end else begin
						r.slot = pos[6:0];
						fill_tab[band] = fill_tab[band] + 8'd1;
					end
				end
			end
			MODE_SORT_DONE: begin
				frame_q  = frame_q + 2'd1;
				load_idx = '0;
				total_q  = '0;
			end
			MODE_FRAME_START: begin
				ring_q   = '0;
				copy_idx = '0;
			end
			MODE_LINE: begin
				if (copy_idx >= BANDS) begin
					r.status = STATUS_NO_BAND;
				end else begin
					start = int'(start_tab[copy_idx]);
					n     = int'(size_tab[copy_idx]);
					room  = (start < STORE_SLOTS) ? STORE_SLOTS - start : 0;
					if (n > RING_SLOTS) n = RING_SLOTS;
					if (n > room) n = room;
					// split where the ring wraps; the tail lands at ring slot 0
					if (int'(ring_q) + n > RING_SLOTS) begin
						head_len = RING_SLOTS - int'(ring_q);
						tail_len = n - head_len;
					end else begin
						head_len = n;
						tail_len = 0;
					end
					if (head_len != 0) begin
						r.first_source = start[6:0];
						r.first_dest   = ring_q;
						r.first_length = head_len[7:0];
					end
					if (tail_len != 0) begin
						pos = start + head_len;
						r.second_source = pos[6:0];
						r.second_length = tail_len[7:0];
					end
					pos = (int'(ring_q) + n) % RING_SLOTS;
					ring_q = pos[6:0];
					copy_idx = copy_idx + 1'b1;
				end
			end
			default: begin
			end
		endcase
		t = (8 * int'(copy_idx) + int'(LINE_OFFSET)) % int'(LINE_PERIOD);
		r.next_line = (copy_idx < BANDS) ? t[7:0] : 8'd0;
		return r;
	endfunction

	task automatic report_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$display("  %s: expected %0d, got %0d", name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BANDS; b++) begin
				size_tab[b]  = '0;
				start_tab[b] = '0;
				fill_tab[b]  = '0;
			end
			total_q  = '0;
			load_idx = '0;
			copy_idx = '0;
			frame_q  = '0;
			ring_q   = '0;
			expected_q.delete();
			fail_count    = 0;
			pending       = 0;
			checked_count = 0;
			dropped_count = 0;
			split_count   = 0;
		end else begin
			// result side first: an item taken at this edge cannot have its result out yet
			if (out_valid && !out_stall) begin
				got = {slot, attr_zero, attr_one, attr_two, first_source, first_dest,
					first_length, second_source, second_length, next_line, status};
				if (expected_q.size() == 0) begin
					if (fail_count < MAX_REPORTS) begin
						$display("unexpected result with nothing outstanding: slot %0d status %0d",
							slot, status);
					end
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						if (fail_count < MAX_REPORTS) begin
							$display("mismatch on result %0d:", checked_count);
							report_field("slot", want.slot, got.slot);
							report_field("attr_zero", want.attr_zero, got.attr_zero);
							report_field("attr_one", want.attr_one, got.attr_one);
							report_field("attr_two", want.attr_two, got.attr_two);
							report_field("first_source", want.first_source, got.first_source);
							report_field("first_dest", want.first_dest, got.first_dest);
							report_field("first_length", want.first_length, got.first_length);
							report_field("second_source", want.second_source, got.second_source);
							report_field("second_length", want.second_length, got.second_length);
							report_field("next_line", want.next_line, got.next_line);
							report_field("status", want.status, got.status);
						end
						fail_count++;
					end
					checked_count++;
				end
			end
			if (in_valid && !in_stall) begin
				seen_item.mode       = mode;
				seen_item.band_count = band_count;
				seen_item.sprite_x   = sprite_x;
				seen_item.sprite_y   = sprite_y;
				want = predict_band_result(seen_item);
				if (want.status == STATUS_BAD_BAND || want.status == STATUS_FULL) begin
					dropped_count++;
				end
				if (want.second_length != 0) begin
					split_count++;
				end
				expected_q.push_back(want);
			end
			pending = expected_q.size();
		end
	end

endmodule

// ----- tb/sprite_band_bucket_multiplexer_tb.sv -----
`timescale 1ns / 1ps
// sprite_band_bucket_multiplexer_tb: stimulus, flow control and verdict for the sprite band
// bucket multiplexer; prediction and comparison live in sbbm_result_checker
// depends on sbbm_pkg, sbbm_result_checker and the block itself
module sprite_band_bucket_multiplexer_tb;
	import sbbm_pkg::*;

	localparam int BANDS       = 21;
	localparam int RING_SLOTS  = 128;
	localparam int STORE_SLOTS = 128;

	// modes 5..7 are not decoded by the block; it must answer them with a plain status
	localparam logic [2:0] MODE_UNUSED = 3'd5;

	localparam int ITEM_TARGET  = 1050;
	localparam int CALM_ITEMS   = 150;     // tail of the run with no idling on either side
	localparam int HOLD_AT      = 300;     // receiver holds off from this transfer on
	localparam int HOLD_CYCLES  = 60;
	localparam int PAUSE_AT     = 650;     // sender waits here until every result is back
	localparam int DRAIN_CYCLES = 8;       // margin after the last result for stray results
	localparam int CYCLE_LIMIT  = 250000;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        mode;
	logic [7:0]        band_count;
	logic [8:0]        sprite_x;
	logic signed [8:0] sprite_y;
	logic              out_valid;
	logic              out_stall;
	logic [6:0]        slot;
	logic [15:0]       attr_zero;
	logic [15:0]       attr_one;
	logic [15:0]       attr_two;
	logic [6:0]        first_source;
	logic [6:0]        first_dest;
	logic [7:0]        first_length;
	logic [6:0]        second_source;
	logic [7:0]        second_length;
	logic [7:0]        next_line;
	logic [1:0]        status;

	int fail_count;
	int pending;
	int checked_count;
	int dropped_count;
	int split_count;

	// flow control shared between the sender and the receiver
	bit hold_req    = 1'b0;
	bit hold_done   = 1'b0;
	bit calm        = 1'b0;
	int idle_pct    = 10;
	int cycle_count = 0;

	item_t stim_q [$];

	sprite_band_bucket_multiplexer #(
		.BANDS       (BANDS),
		.RING_SLOTS  (RING_SLOTS),
		.STORE_SLOTS (STORE_SLOTS)
	) u_dut (.*);

	sbbm_result_checker #(
		.BANDS       (BANDS),
		.RING_SLOTS  (RING_SLOTS),
		.STORE_SLOTS (STORE_SLOTS)
	) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// a hung handshake or a lost result ends here
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still outstanding", cycle_count, pending);
		$display("sprite_band_bucket_multiplexer regression: fail");
		$finish;
	end

	// idling comes in phases: none, light, heavy; this gives long clean stretches as well
	initial begin : idle_phases
		forever begin
			repeat (200) @(posedge clk);
			case ($urandom_range(0, 2))
				0: begin
					idle_pct = 0;
				end
				1: begin
					idle_pct = 8;
				end
				default: begin
					idle_pct = 25;
				end
			endcase
		end
	end

	task automatic add_item(input logic [2:0] m, input int cnt, input int x, input int y);
		item_t it;
		it.mode       = m;
		it.band_count = cnt[7:0];
		it.sprite_x   = x[8:0];
		it.sprite_y   = y[8:0];
		stim_q.push_back(it);
	endtask

	// fields that the mode ignores still get random values
	task automatic add_op(input logic [2:0] m);
		add_item(m, $urandom_range(0, 128), $urandom_range(0, 511),
			int'($urandom_range(0, 383)) - 128);
	endtask

	// mostly small bands so that the store holds a whole frame, now and then a big one
	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 39);
		if (r == 0) return 128;
		if (r < 5) return $urandom_range(0, 128);
		return $urandom_range(0, 12);
	endfunction

	// one frame: load a band table, bin sprites, finish the sort, then copy band by band
	task automatic add_frame();
		int nload;
		int nsprite;
		int ncopy;
		int band;
		int y;
		// stray items, unused modes among them
		repeat ($urandom_range(0, 2)) add_op(3'($urandom_range(0, 7)));
		// a few passes run past the end of the table
		nload = BANDS - 2 + $urandom_range(0, 4);
		repeat (nload) begin
			add_item(MODE_COUNT, pick_count(), $urandom_range(0, 511), $urandom_range(0, 255));
		end
		nsprite = $urandom_range(8, 40);
		repeat (nsprite) begin
			if ($urandom_range(0, 7) == 0) begin
				y = int'($urandom_range(0, 383)) - 128;
			end else begin
				band = $urandom_range(0, BANDS - 1);
				y = band * 8 - 8 + int'($urandom_range(0, 7));
			end
			add_item(MODE_SPRITE, $urandom_range(0, 128), $urandom_range(0, 511), y);
		end
		add_op(MODE_SORT_DONE);
		// now and then the frame start is missed and the copy finds no band left
		if ($urandom_range(0, 7) != 0) begin
			add_op(MODE_FRAME_START);
		end
		ncopy = BANDS - 1 + $urandom_range(0, 3);
		for (int c = 0; c < ncopy; c++) begin
			add_op(MODE_LINE);
			// reload mid-copy with the remaining bands packed from slot 0: the ring pointer
			// is already part way round, so the next copies tend to wrap
			if ($urandom_range(0, 11) == 0) begin
				add_op(MODE_SORT_DONE);
				for (int b = 0; b < BANDS; b++) begin
					add_item(MODE_COUNT, (b <= c) ? 0 : pick_count(), $urandom_range(0, 511), 0);
				end
			end
		end
	endtask

	// receiver: random stall bursts, one long hold-off on request, none near the end
	initial begin : result_sink
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// sender: builds the stimulus, resets the block, offers every item, gives the verdict
	initial begin : item_source
		int  gap;
		bit  drain;
		in_valid   = 1'b0;
		mode       = MODE_COUNT;
		band_count = '0;
		sprite_x   = '0;
		sprite_y   = '0;
		arst_n     = 1'b0;

		// directed: band table with a full-size band, a saturating total and a band whose
		// start lies past the store
		add_item(MODE_COUNT, 100, 0, 0);
		add_item(MODE_COUNT, 128, 511, -128);
		add_item(MODE_COUNT, 0, 0, 0);
		add_item(MODE_COUNT, 3, 0, 0);
		add_item(MODE_COUNT, 128, 0, 0);
		// sprites below and above the table, the band 0 edge, empty and overfull buckets
		add_item(MODE_SPRITE, 0, 0, -128);
		add_item(MODE_SPRITE, 128, 511, -16);
		add_item(MODE_SPRITE, 0, 341, -15);
		add_item(MODE_SPRITE, 0, 170, -9);
		add_item(MODE_SPRITE, 0, 0, 255);
		add_item(MODE_SPRITE, 0, 0, 160);
		add_item(MODE_SPRITE, 0, 0, 159);
		add_item(MODE_SPRITE, 0, 511, 0);
		add_item(MODE_SPRITE, 0, 0, 16);
		// sort done steps the animation frame; band 1 keeps filling
		add_op(MODE_SORT_DONE);
		add_item(MODE_SPRITE, 0, 1, 7);
		// copy band 0 whole, then reload band 1 from slot 0 so that its copy wraps the ring
		add_op(MODE_FRAME_START);
		add_op(MODE_LINE);
		add_item(MODE_COUNT, 0, 0, 0);
		add_item(MODE_COUNT, 60, 0, 0);
		add_op(MODE_LINE);
		// an empty band, then a band with no store room left
		add_op(MODE_LINE);
		add_op(MODE_LINE);
		add_op(MODE_UNUSED);
		add_op(MODE_SORT_DONE);
		add_op(MODE_FRAME_START);

		while (stim_q.size() < ITEM_TARGET) begin
			add_frame();
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < stim_q.size(); i++) begin
			calm = (i >= stim_q.size() - CALM_ITEMS);
			if (i == HOLD_AT) begin
				hold_req = 1'b1;
			end
			drain = (i == PAUSE_AT);
			gap = 0;
			// no gaps while the receiver holds off, so that the block backs up
			if (!calm && !(hold_req && !hold_done) && $urandom_range(0, 99) < idle_pct) begin
				gap = $urandom_range(1, 13);
			end
			if (drain || gap != 0) begin
				in_valid <= 1'b0;
				if (drain) begin
					do @(posedge clk); while (pending != 0);
				end
				repeat (gap) @(posedge clk);
			end
			in_valid   <= 1'b1;
			mode       <= stim_q[i].mode;
			band_count <= stim_q[i].band_count;
			sprite_x   <= stim_q[i].sprite_x;
			sprite_y   <= stim_q[i].sprite_y;
			// the transfer happens at the first edge with stall low
			do @(posedge clk); while (in_stall);
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d item transfers and %0d checked results in %0d cycles",
			stim_q.size(), checked_count, cycle_count);
		$display("%0d sprites dropped, %0d copies split at the ring wrap, one %0d-cycle hold-off",
			dropped_count, split_count, HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("sprite_band_bucket_multiplexer regression: pass");
		end else begin
			$display("%0d mismatching results", fail_count);
			$display("sprite_band_bucket_multiplexer regression: fail");
		end
		$finish;
	end

endmodule
